>>> src/lphm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the linear-probing hash map
// no dependencies
package lphm_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int OCC_W  = SLOT_W + 1;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OCC_W-1:0]  occ_t;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL_ACK  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_FIND,
    CMD_CLEAR,
    CMD_ANSWER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    status_t          answer;
    logic [KEY_W-1:0] tag;
    logic [VAL_W-1:0] value;
    slot_t            home;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_VALUE
  } bk_state_t;

endpackage

>>> src/lphm_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready plus request type, key and value
// depends on lphm_pkg
interface lphm_req_if;
  import lphm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

>>> src/lphm_rsp_if.sv
`timescale 1ns / 1ps
// response channel: valid/ready plus status and looked-up value
// depends on lphm_pkg
interface lphm_rsp_if;
  import lphm_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [VAL_W-1:0] value_out;

  modport source (output valid, output status, output value_out, input ready);
  modport sink   (input valid, input status, input value_out, output ready);
endinterface

>>> src/lphm_front.sv
`timescale 1ns / 1ps
// front end: hashes the key and classifies each request into a queue command
// depends on lphm_pkg and lphm_req_if
module lphm_front (
  lphm_req_if.sink       req,
  input  logic           q_full,
  output logic           q_push,
  output lphm_pkg::cmd_t q_cmd
);
  import lphm_pkg::*;

  logic [KEY_W-1:0] prod;
  logic             key_ones;

  assign prod      = req.key * HASH_MULT;
  assign key_ones  = &req.key;
  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  always_comb begin
    q_cmd.tag    = req.key + KEY_W'(1);
    q_cmd.value  = req.value;
    q_cmd.home   = prod[SLOT_W-1:0];
    q_cmd.kind   = CMD_ANSWER;
    q_cmd.answer = STAT_NOT_FOUND;
    unique case (req.req_type)
      REQ_INSERT: begin
        // all-ones key would store the empty mark
        if (key_ones) begin
          q_cmd.answer = STAT_FULL_ACK;
        end else begin
          q_cmd.kind = CMD_INSERT;
        end
      end
      REQ_FIND: begin
        if (!key_ones) begin
          q_cmd.kind = CMD_FIND;
        end
      end
      REQ_CLEAR: begin
        q_cmd.kind = CMD_CLEAR;
      end
      default: begin
        q_cmd.answer = STAT_NOT_FOUND;
      end
    endcase
  end
endmodule

>>> src/lphm_queue.sv
`timescale 1ns / 1ps
// short command queue decoupling front and back
// depends on lphm_pkg
module lphm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lphm_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lphm_pkg::cmd_t dout
);
  import lphm_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign dout      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end
endmodule

>>> src/lphm_back.sv
`timescale 1ns / 1ps
// back end: probe engine over the slot memories and the response register
// depends on lphm_pkg and lphm_rsp_if
module lphm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lphm_pkg::cmd_t q_cmd,
  output logic           q_pop,
  lphm_rsp_if.source     rsp
);
  import lphm_pkg::*;

  bk_state_t state, state_next;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0] slot_valid;

  cmd_t             cur;
  slot_t            addr;
  slot_t            count;
  occ_t             occ;
  logic [KEY_W-1:0] key_rd;
  logic             valid_rd;
  logic [VAL_W-1:0] val_rd;

  logic             out_valid;
  status_t          out_status;
  logic [VAL_W-1:0] out_value;

  logic             can_load;
  logic             load;
  logic             ld_found;
  status_t          ld_status;
  logic             key_rd_en;
  logic             val_rd_en;
  logic             wr_en;
  logic             clr;
  logic             start;
  logic             step;
  logic [KEY_W-1:0] slot_key;

  assign can_load      = !out_valid || rsp.ready;
  assign slot_key      = valid_rd ? key_rd : '0;
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.value_out = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    ld_found   = 1'b0;
    ld_status  = STAT_NOT_FOUND;
    key_rd_en  = 1'b0;
    val_rd_en  = 1'b0;
    wr_en      = 1'b0;
    clr        = 1'b0;
    start      = 1'b0;
    step       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind) inside
            CMD_INSERT, CMD_FIND: begin
              q_pop      = 1'b1;
              start      = 1'b1;
              state_next = BK_READ;
            end
            CMD_CLEAR: begin
              if (can_load) begin
                q_pop     = 1'b1;
                clr       = 1'b1;
                load      = 1'b1;
                ld_status = STAT_FULL_ACK;
              end
            end
            default: begin
              if (can_load) begin
                q_pop     = 1'b1;
                load      = 1'b1;
                ld_status = q_cmd.answer;
              end
            end
          endcase
        end
      end
      BK_READ: begin
        key_rd_en  = 1'b1;
        state_next = BK_CHECK;
      end
      BK_CHECK: begin
        if (slot_key == cur.tag) begin
          if (cur.kind == CMD_FIND) begin
            val_rd_en  = 1'b1;
            state_next = BK_VALUE;
          end else if (can_load) begin
            load       = 1'b1;
            ld_status  = STAT_DUPLICATE;
            state_next = BK_IDLE;
          end
        end else if (slot_key == '0 || count == slot_t'(SLOTS - 1)) begin
          // empty slot reached, or every slot probed once
          if (can_load) begin
            load       = 1'b1;
            state_next = BK_IDLE;
            if (cur.kind == CMD_INSERT) begin
              if (slot_key == '0 && !occ[OCC_W-1]) begin
                wr_en     = 1'b1;
                ld_status = STAT_INSERTED;
              end else begin
                ld_status = STAT_FULL_ACK;
              end
            end else begin
              ld_status = STAT_NOT_FOUND;
            end
          end
        end else begin
          step       = 1'b1;
          state_next = BK_READ;
        end
      end
      BK_VALUE: begin
        if (can_load) begin
          load       = 1'b1;
          ld_found   = 1'b1;
          ld_status  = STAT_FOUND;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[addr] <= cur.tag;
    end
    if (key_rd_en) begin
      key_rd <= key_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[addr] <= cur.value;
    end
    if (val_rd_en) begin
      val_rd <= val_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      occ        <= '0;
    end else if (clr) begin
      slot_valid <= '0;
      occ        <= '0;
    end else if (wr_en) begin
      slot_valid[addr] <= 1'b1;
      occ              <= occ + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (key_rd_en) begin
      valid_rd <= slot_valid[addr];
    end
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (start) begin
      addr  <= q_cmd.home;
      count <= '0;
    end else if (step) begin
      addr  <= addr + SLOT_W'(1);
      count <= count + SLOT_W'(1);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_value  <= ld_found ? val_rd : '0;
    end
  end
endmodule

>>> src/linear_probe_hash_map_top.sv
`timescale 1ns / 1ps
// top level of the linear-probing hash map: front, command queue, back
// depends on lphm_pkg, lphm_req_if, lphm_rsp_if, lphm_front, lphm_queue, lphm_back
//
// usage
//   req channel: one beat per request (insert key/value, find key, clear table)
//   rsp channel: exactly one beat per request, in request order
//   the front hashes and classifies each request and drops it into a
//   two-entry command queue; req.ready is low only while that queue is full
//   the back walks the table one slot at a time: a registered key read
//   (BK_READ), then a compare (BK_CHECK); a hit on find then reads the
//   value memory (BK_VALUE) before it answers
//   clear and trivially answered requests are answered from the idle state
//   the probe loop over the single key memory port sets the throughput
//   reset empties the table at once (per-slot valid flops) and drops any
//   queued work; no clearing pass is needed
//   a stalled response sits in the output register; the back keeps working
//   until it needs that register again, and the queue keeps taking beats
module linear_probe_hash_map_top (
  input logic        clk,
  input logic        rst,
  lphm_req_if.sink   req,
  lphm_rsp_if.source rsp
);
  import lphm_pkg::*;

  // front to queue
  logic q_push;
  logic q_full;
  cmd_t q_din;

  // queue to back
  logic q_pop;
  logic q_not_empty;
  cmd_t q_dout;

  // hash and classify, no state
  lphm_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_din)
  );

  // decouples request acceptance from the probe walk
  lphm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_dout)
  );

  // probe engine, slot memories and response register
  lphm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_cmd   (q_dout),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );
endmodule

>>> src/lphm_checker.sv
`timescale 1ns / 1ps
// port-level checks of the hash map, bound to the top level
// depends on lphm_pkg and linear_probe_hash_map_top
module lphm_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [2:0]              rsp_status,
  input logic [lphm_pkg::VAL_W-1:0] rsp_value_out
);
  import lphm_pkg::*;

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response beat right after reset");

  // a stalled response holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value_out))
    else $error("stalled response changed");

  // value only carried on a hit
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_FOUND |-> rsp_value_out == '0)
    else $error("value_out nonzero without a hit");

  // no status code beyond full/ack
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == STAT_INSERTED || rsp_status == STAT_DUPLICATE ||
                  rsp_status == STAT_FOUND || rsp_status == STAT_NOT_FOUND ||
                  rsp_status == STAT_FULL_ACK)
    else $error("undefined status code");
endmodule

bind linear_probe_hash_map_top lphm_checker u_lphm_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_value_out (rsp.value_out)
);
